[rtl/core/lzwd_pkg.sv]
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants and types of the LZW decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwd_pkg;

   localparam int CODE_BITS      = 12;
   localparam int MAX_STRING_LEN = 64;
   localparam int ALPHABET       = 256;
   localparam int BYTE_W         = 8;

   localparam int DICT_DEPTH = 1 << CODE_BITS;
   localparam int NFC_W      = CODE_BITS + 1;
   localparam int LEN_W      = $clog2(MAX_STRING_LEN + 1);
   localparam int STACK_AW   = $clog2(MAX_STRING_LEN);

   localparam logic [NFC_W-1:0]     NFC_RESET  = NFC_W'(ALPHABET);
   localparam logic [NFC_W-1:0]     NFC_LIMIT  = NFC_W'(DICT_DEPTH);
   localparam logic [LEN_W-1:0]     LEN_CAP    = LEN_W'(MAX_STRING_LEN);
   localparam logic [LEN_W-1:0]     LEN_ONE    = LEN_W'(1);
   localparam logic [CODE_BITS-1:0] CODE_ALPHA = CODE_BITS'(ALPHABET);

   typedef enum logic {
      F_IDLE,
      F_EVAL
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_WREQ,
      B_WDAT,
      B_FINAL,
      B_RD,
      B_OUT
   } back_state_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic                 bad;
   } job_type;

   typedef struct packed {
      logic                 en;
      logic [CODE_BITS-1:0] addr;
      logic [CODE_BITS-1:0] prefix;
      logic [BYTE_W-1:0]    suffix;
   } dict_wr_type;

endpackage

`default_nettype wire

[rtl/core/lzwd_ram.sv]
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/lzwd_fifo.sv]
// ----------------------------------------------------------------------------
// lzwd_fifo
// Two-entry job queue between the code classifier and the string walker.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire lzwd_pkg::job_type push_data,
   output      logic             full,
   input  wire logic             pop,
   output      lzwd_pkg::job_type pop_data,
   output      logic             empty
);

   lzwd_pkg::job_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lzwd_front.sv]
// ----------------------------------------------------------------------------
// lzwd_front
// Accepts codes, checks them against the dictionary and adds new entries.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   output      logic                               req_full,
   input  wire logic [lzwd_pkg::CODE_BITS-1:0]     req_code,
   input  wire logic                               req_first,
   input  wire logic                               job_full,
   input  wire logic                               drained,
   output      logic                               job_push,
   output      lzwd_pkg::job_type                  job_data,
   output      lzwd_pkg::dict_wr_type              dict_wr
);

   lzwd_pkg::front_state_type state_ff, state_in;

   logic [lzwd_pkg::CODE_BITS-1:0] code_ff;
   logic                           first_ff;
   logic [lzwd_pkg::NFC_W-1:0]     nfc_ff, nfc_in;
   logic [lzwd_pkg::CODE_BITS-1:0] prev_ff, prev_in;
   logic [lzwd_pkg::BYTE_W-1:0]    prev_head_ff, prev_head_in;
   logic [lzwd_pkg::LEN_W-1:0]     prev_len_ff, prev_len_in;

   logic                           accept, go, add;
   logic [lzwd_pkg::NFC_W-1:0]     nfc_eff, code_ext;
   logic [lzwd_pkg::CODE_BITS-1:0] prev_eff;
   logic [lzwd_pkg::BYTE_W-1:0]    head_eff, code_head, rd_head;
   logic [lzwd_pkg::LEN_W-1:0]     len_eff, code_len, rd_len;
   logic                           can_add, is_new, is_byte, bad;
   logic [lzwd_pkg::BYTE_W+lzwd_pkg::LEN_W-1:0] hl_rd, hl_wr;

   assign accept = req_push && !req_full;

   // head byte and length of every entry, read at the incoming code
   lzwd_ram #(
      .WIDTH(lzwd_pkg::BYTE_W + lzwd_pkg::LEN_W),
      .DEPTH(lzwd_pkg::DICT_DEPTH)
   ) u_head_len (
      .clock   (clock),
      .wr_en   (add),
      .wr_addr (nfc_eff[lzwd_pkg::CODE_BITS-1:0]),
      .wr_data (hl_wr),
      .rd_en   (accept),
      .rd_addr (req_code),
      .rd_data (hl_rd)
   );

   assign rd_head = hl_rd[lzwd_pkg::BYTE_W+lzwd_pkg::LEN_W-1:lzwd_pkg::LEN_W];
   assign rd_len  = hl_rd[lzwd_pkg::LEN_W-1:0];

   always_comb begin
      nfc_eff  = first_ff ? lzwd_pkg::NFC_RESET : nfc_ff;
      prev_eff = first_ff ? '0 : prev_ff;
      head_eff = first_ff ? '0 : prev_head_ff;
      len_eff  = first_ff ? lzwd_pkg::LEN_ONE : prev_len_ff;
      code_ext = {1'b0, code_ff};
      is_byte  = code_ff < lzwd_pkg::CODE_ALPHA;
      is_new   = code_ext == nfc_eff;
      can_add  = !first_ff && (nfc_eff < lzwd_pkg::NFC_LIMIT) && (len_eff < lzwd_pkg::LEN_CAP);
      bad      = (code_ext > nfc_eff) || (first_ff && !is_byte) || (is_new && !can_add);
      if (is_byte) begin
         code_head = code_ff[lzwd_pkg::BYTE_W-1:0];
         code_len  = lzwd_pkg::LEN_ONE;
      end else if (is_new) begin
         code_head = head_eff;
         code_len  = len_eff + lzwd_pkg::LEN_ONE;
      end else begin
         code_head = rd_head;
         code_len  = rd_len;
      end
   end

   assign go  = (state_ff == lzwd_pkg::F_EVAL) && !job_full && (!first_ff || drained);
   assign add = go && !bad && can_add;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lzwd_pkg::F_IDLE: begin
            if (accept) state_in = lzwd_pkg::F_EVAL;
         end
         lzwd_pkg::F_EVAL: begin
            if (go) state_in = lzwd_pkg::F_IDLE;
         end
         default: state_in = lzwd_pkg::F_IDLE;
      endcase
   end

   // outputs and dictionary update
   always_comb begin
      req_full      = state_ff != lzwd_pkg::F_IDLE;
      job_push      = go;
      job_data.code = code_ff;
      job_data.bad  = bad;
      hl_wr         = {head_eff, len_eff + lzwd_pkg::LEN_ONE};
      dict_wr.en     = add;
      dict_wr.addr   = nfc_eff[lzwd_pkg::CODE_BITS-1:0];
      dict_wr.prefix = prev_eff;
      dict_wr.suffix = code_head;
      nfc_in       = nfc_ff;
      prev_in      = prev_ff;
      prev_head_in = prev_head_ff;
      prev_len_in  = prev_len_ff;
      if (go) begin
         nfc_in       = add ? nfc_eff + lzwd_pkg::NFC_W'(1) : nfc_eff;
         prev_in      = bad ? prev_eff : code_ff;
         prev_head_in = bad ? head_eff : code_head;
         prev_len_in  = bad ? len_eff : code_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzwd_pkg::F_IDLE;
         nfc_ff       <= lzwd_pkg::NFC_RESET;
         prev_ff      <= '0;
         prev_head_ff <= '0;
         prev_len_ff  <= lzwd_pkg::LEN_ONE;
      end else begin
         state_ff     <= state_in;
         nfc_ff       <= nfc_in;
         prev_ff      <= prev_in;
         prev_head_ff <= prev_head_in;
         prev_len_ff  <= prev_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff  <= req_code;
         first_ff <= req_first;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lzwd_back.sv]
// ----------------------------------------------------------------------------
// lzwd_back
// Walks each valid job's prefix chain and emits its string byte by byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           job_empty,
   input  wire lzwd_pkg::job_type              job_data,
   output      logic                           job_pop,
   output      logic                           back_idle,
   input  wire lzwd_pkg::dict_wr_type          dict_wr,
   output      logic                           rsp_empty,
   input  wire logic                           rsp_pop,
   output      logic [lzwd_pkg::BYTE_W-1:0]    rsp_data_byte,
   output      logic                           rsp_last,
   output      logic                           rsp_error
);

   lzwd_pkg::back_state_type state_ff, state_in;

   logic [lzwd_pkg::CODE_BITS-1:0] walk_ff, walk_in;
   logic [lzwd_pkg::STACK_AW-1:0]  depth_ff, depth_in;
   logic                           out_valid_ff, out_valid_in;
   logic [lzwd_pkg::BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic                           out_last_ff, out_last_in;
   logic                           out_err_ff, out_err_in;

   logic                           out_free;
   logic                           dict_rd_en, stack_wr_en, stack_rd_en;
   logic [lzwd_pkg::BYTE_W-1:0]    stack_wr_data, stack_rd_data;
   logic [lzwd_pkg::CODE_BITS+lzwd_pkg::BYTE_W-1:0] dict_rd;
   logic [lzwd_pkg::CODE_BITS-1:0] rd_prefix;
   logic [lzwd_pkg::BYTE_W-1:0]    rd_suffix;

   lzwd_ram #(
      .WIDTH(lzwd_pkg::CODE_BITS + lzwd_pkg::BYTE_W),
      .DEPTH(lzwd_pkg::DICT_DEPTH)
   ) u_dict (
      .clock   (clock),
      .wr_en   (dict_wr.en),
      .wr_addr (dict_wr.addr),
      .wr_data ({dict_wr.prefix, dict_wr.suffix}),
      .rd_en   (dict_rd_en),
      .rd_addr (walk_ff),
      .rd_data (dict_rd)
   );

   // bytes come off the chain last first, so they are stacked and read back
   lzwd_ram #(
      .WIDTH(lzwd_pkg::BYTE_W),
      .DEPTH(lzwd_pkg::MAX_STRING_LEN)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (depth_ff),
      .wr_data (stack_wr_data),
      .rd_en   (stack_rd_en),
      .rd_addr (depth_ff),
      .rd_data (stack_rd_data)
   );

   assign rd_prefix = dict_rd[lzwd_pkg::CODE_BITS+lzwd_pkg::BYTE_W-1:lzwd_pkg::BYTE_W];
   assign rd_suffix = dict_rd[lzwd_pkg::BYTE_W-1:0];
   assign out_free  = !out_valid_ff || rsp_pop;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lzwd_pkg::B_IDLE: begin
            if (!job_empty && !job_data.bad) begin
               state_in = (job_data.code < lzwd_pkg::CODE_ALPHA) ?
                          lzwd_pkg::B_FINAL : lzwd_pkg::B_WREQ;
            end
         end
         lzwd_pkg::B_WREQ: state_in = lzwd_pkg::B_WDAT;
         lzwd_pkg::B_WDAT: begin
            state_in = (rd_prefix < lzwd_pkg::CODE_ALPHA) ? lzwd_pkg::B_FINAL : lzwd_pkg::B_WREQ;
         end
         lzwd_pkg::B_FINAL: state_in = lzwd_pkg::B_RD;
         lzwd_pkg::B_RD: begin
            if (out_free) state_in = lzwd_pkg::B_OUT;
         end
         lzwd_pkg::B_OUT: begin
            if (depth_ff == '0) state_in = lzwd_pkg::B_IDLE;
            else                state_in = lzwd_pkg::B_RD;
         end
         default: state_in = lzwd_pkg::B_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      job_pop       = 1'b0;
      dict_rd_en    = 1'b0;
      stack_wr_en   = 1'b0;
      stack_wr_data = rd_suffix;
      stack_rd_en   = 1'b0;
      walk_in       = walk_ff;
      depth_in      = depth_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_err_in    = out_err_ff;
      case (state_ff)
         lzwd_pkg::B_IDLE: begin
            if (!job_empty) begin
               if (job_data.bad) begin
                  if (out_free) begin
                     job_pop      = 1'b1;
                     out_valid_in = 1'b1;
                     out_byte_in  = '0;
                     out_last_in  = 1'b1;
                     out_err_in   = 1'b1;
                  end
               end else begin
                  job_pop  = 1'b1;
                  walk_in  = job_data.code;
                  depth_in = '0;
               end
            end
         end
         lzwd_pkg::B_WREQ: dict_rd_en = 1'b1;
         lzwd_pkg::B_WDAT: begin
            stack_wr_en = 1'b1;
            walk_in     = rd_prefix;
            depth_in    = depth_ff + lzwd_pkg::STACK_AW'(1);
         end
         lzwd_pkg::B_FINAL: begin
            stack_wr_en   = 1'b1;
            stack_wr_data = walk_ff[lzwd_pkg::BYTE_W-1:0];
         end
         lzwd_pkg::B_RD: stack_rd_en = out_free;
         lzwd_pkg::B_OUT: begin
            out_valid_in = 1'b1;
            out_byte_in  = stack_rd_data;
            out_last_in  = depth_ff == '0;
            out_err_in   = 1'b0;
            if (depth_ff != '0) depth_in = depth_ff - lzwd_pkg::STACK_AW'(1);
         end
         default: ;
      endcase
   end

   assign back_idle     = state_ff == lzwd_pkg::B_IDLE;
   assign rsp_empty     = !out_valid_ff;
   assign rsp_data_byte = out_byte_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_error     = out_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzwd_pkg::B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff     <= walk_in;
      depth_ff    <= depth_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

endmodule

`default_nettype wire

[rtl/core/lzw_decoder_top.sv]
// ----------------------------------------------------------------------------
// lzw_decoder_top
// LZW decoder, 12-bit codes: one code in, its string out one byte per result.
// ----------------------------------------------------------------------------
// steps: the classifier checks a code; the walker uses a read request and a
//   data state per chain link, a final state for the root byte, and a stack
//   read (held until the output is free) and an output state per byte; the
//   classifier queues its job and takes the next code while the walker runs
// reset: synchronous; dictionary restarts at code 256, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_decoder_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   output      logic                               req_full,
   input  wire logic [lzwd_pkg::CODE_BITS-1:0]     req_code,
   input  wire logic                               req_first,
   output      logic                               rsp_empty,
   input  wire logic                               rsp_pop,
   output      logic [lzwd_pkg::BYTE_W-1:0]        rsp_data_byte,
   output      logic                               rsp_last,
   output      logic                               rsp_error
);

   lzwd_pkg::job_type     push_job, pop_job;
   lzwd_pkg::dict_wr_type dict_wr;
   logic                  job_push, job_full, job_pop, job_empty, back_idle;

   lzwd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_code  (req_code),
      .req_first (req_first),
      .job_full  (job_full),
      .drained   (job_empty && back_idle),
      .job_push  (job_push),
      .job_data  (push_job),
      .dict_wr   (dict_wr)
   );

   lzwd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (pop_job),
      .empty     (job_empty)
   );

   lzwd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_empty     (job_empty),
      .job_data      (pop_job),
      .job_pop       (job_pop),
      .back_idle     (back_idle),
      .dict_wr       (dict_wr),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data_byte (rsp_data_byte),
      .rsp_last      (rsp_last),
      .rsp_error     (rsp_error)
   );

endmodule

`default_nettype wire
